[rtl/bounded_sorted_measurement_list_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded sorted measurement list
// Concurrent assertion shorthands clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SORTED_MEASUREMENT_LIST_DEFINES_SVH
`define BOUNDED_SORTED_MEASUREMENT_LIST_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSML_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bsml_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded sorted measurement list package
// Field widths, the stored entry layout and the sequencer states.
// ----------------------------------------------------------------------------
package bsml_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned RangeW = 16;
  localparam int unsigned BrgW   = 16;
  localparam int unsigned PosW   = 17;
  localparam int unsigned SlotW  = 5;

  // One stored measurement.
  typedef struct packed {
    logic [TimeW-1:0]       timestamp;
    logic [RangeW-1:0]      range_mm;
    logic [BrgW-1:0]        bearing;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } state_e;

endpackage

[rtl/bsml_if.sv]
// ----------------------------------------------------------------------------
// Bounded sorted measurement list channels
// Valid/ready channels for input measurements and for insertion results.
// ----------------------------------------------------------------------------
interface bsml_meas_if;
  import bsml_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TimeW-1:0]       timestamp;
  logic [RangeW-1:0]      range_mm;
  logic [BrgW-1:0]        bearing;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;

  modport source (output valid, timestamp, range_mm, bearing, pos_x, pos_y, input ready);
  modport sink   (input valid, timestamp, range_mm, bearing, pos_x, pos_y, output ready);
endinterface

interface bsml_result_if;
  import bsml_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic [SlotW-1:0]  slot;
  logic [SlotW-1:0]  entry_count;
  logic [RangeW-1:0] front_range;

  modport source (output valid, accepted, slot, entry_count, front_range, input ready);
  modport sink   (input valid, accepted, slot, entry_count, front_range, output ready);
endinterface

[rtl/bounded_sorted_measurement_list.sv]
// ----------------------------------------------------------------------------
// Bounded sorted measurement list
// Keeps up to MAX_ENTRIES measurements sorted newest first, nearest first.
// ----------------------------------------------------------------------------
// Usage:
// Measurements arrive on in_i and one result item per measurement leaves on
// out_o; both are valid/ready channels and an item moves when valid and ready
// are high at a rising clock edge. in_i.ready is high only while the sequencer
// is idle, so the block works on one measurement at a time.
// After acceptance the sequencer searches for the item's place, comparing it
// with one stored entry at a time from the front until an entry is not passed
// or the list ends. It then moves the entries behind that place down one at a
// time, starting from the end of the list, writes the item and loads the
// result register. A stored item pushes the last entry off a full list; a
// rejection walks the whole list and skips the shift. The sequencer returns
// to idle only after loading the result register, so the block takes no new
// measurement before it is through with the last one.
// Reset empties the list at once through the fill count; entry storage is not
// cleared. A result waits in the output register while the receiver stalls,
// and the next item is already accepted meanwhile; its result waits in the
// final sequencer step until the register frees up.
// ----------------------------------------------------------------------------
module bounded_sorted_measurement_list #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bsml_meas_if.sink          in_i,
  bsml_result_if.source      out_o
);
  import bsml_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MaxC  = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] LastC = CW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] OneC  = CW'(1);
  localparam logic [CW-1:0] TwoC  = CW'(2);

  // Sequencer state, search position n and shift destination s.
  state_e        state_q, state_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] s_q, s_d;
  logic [CW-1:0] count_q, count_d;
  logic          ok_q, ok_d;
  logic [RangeW-1:0] front_q, front_d;

  // The measurement being inserted.
  entry_t item_q;

  // Entry memory: one write and one registered read per cycle.
  entry_t        mem_q [MAX_ENTRIES];
  entry_t        rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // Output register.
  logic              out_valid_q;
  logic              res_accepted_q;
  logic [SlotW-1:0]  res_slot_q;
  logic [SlotW-1:0]  res_count_q;
  logic [RangeW-1:0] res_front_q;
  logic              out_free;
  logic              out_load;

  logic          in_fire;
  logic          skip;
  logic          more;
  logic [CW-1:0] last;
  logic [CW-1:0] n_inc;
  logic [CW-1:0] last_m1;
  logic [CW-1:0] s_m2;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // The list is kept sorted, so one combined test replaces the two passes:
  // walk past entries that are newer, or equally new and nearer.
  assign skip = (item_q.timestamp < rd_data_q.timestamp) ||
                ((item_q.timestamp == rd_data_q.timestamp) &&
                 (item_q.range_mm > rd_data_q.range_mm));
  assign more    = (n_q < count_q) && skip;
  assign last    = (count_q < MaxC) ? count_q : LastC;
  assign n_inc   = n_q + OneC;
  assign last_m1 = last - OneC;
  assign s_m2    = s_q - TwoC;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!more) begin
          // A place past the end of a full list means rejection.
          state_d = (n_q == MaxC) ? ST_DONE : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (s_q == n_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    n_d      = n_q;
    s_d      = s_q;
    count_d  = count_q;
    ok_d     = ok_q;
    front_d  = front_q;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = s_q[AW-1:0];
    wr_data  = rd_data_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // Entry 0 is fetched while the item is taken.
        n_d = '0;
      end
      ST_SEARCH: begin
        if (more) begin
          n_d     = n_inc;
          rd_addr = n_inc[AW-1:0];
        end else begin
          ok_d    = (n_q != MaxC);
          s_d     = last;
          rd_addr = last_m1[AW-1:0];
        end
      end
      ST_SHIFT: begin
        wr_en = 1'b1;
        if (s_q == n_q) begin
          wr_data = item_q;
          if (count_q < MaxC) begin
            count_d = count_q + OneC;
          end
          if (n_q == '0) begin
            front_d = item_q.range_mm;
          end
        end else begin
          // Move entry s-1 down into s and fetch s-2 for the next step.
          s_d     = s_q - OneC;
          rd_addr = s_m2[AW-1:0];
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      s_q     <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
      front_q <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      s_q     <= s_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      front_q <= front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.timestamp <= in_i.timestamp;
      item_q.range_mm  <= in_i.range_mm;
      item_q.bearing   <= in_i.bearing;
      item_q.pos_x     <= in_i.pos_x;
      item_q.pos_y     <= in_i.pos_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Counts are reported modulo 32.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_accepted_q <= ok_q;
      res_slot_q     <= SlotW'(n_q);
      res_count_q    <= SlotW'(count_q);
      res_front_q    <= front_q;
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.accepted    = res_accepted_q;
  assign out_o.slot        = res_slot_q;
  assign out_o.entry_count = res_count_q;
  assign out_o.front_range = res_front_q;

endmodule

[rtl/bsml_checker.sv]
// ----------------------------------------------------------------------------
// Bounded sorted measurement list checker
// Port-level assertions on the result channel and the input handshake.
// ----------------------------------------------------------------------------
`include "bounded_sorted_measurement_list_defines.svh"

module bsml_checker #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          accepted_i,
  input logic [bsml_pkg::SlotW-1:0]    slot_i,
  input logic [bsml_pkg::SlotW-1:0]    entry_count_i
);
  import bsml_pkg::*;

  localparam logic [SlotW-1:0] MaxS  = SlotW'(MAX_ENTRIES);
  localparam logic             Small = (MAX_ENTRIES < 32);

  // A result is held until the receiver takes it.
  `BSML_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i,
    "result item dropped before it was taken")

  // One measurement at a time: taking an item closes the input.
  `BSML_ASSERT_NEXT(a_in_close, in_valid_i && in_ready_i, !in_ready_i,
    "input still open right after an item was taken")

  // A rejection only happens on a full list, which stays unchanged.
  `BSML_ASSERT_NOW(a_reject_full, out_valid_i && !accepted_i,
    (slot_i == MaxS) && (entry_count_i == MaxS),
    "rejected item reported with a list that is not full")

  // A stored item lies inside the list that holds it.
  `BSML_ASSERT_NOW(a_slot_inside, Small && out_valid_i && accepted_i,
    (slot_i < entry_count_i) && (entry_count_i != '0),
    "stored item reported at a slot outside the list")

endmodule

bind bounded_sorted_measurement_list bsml_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_bsml_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .accepted_i    (out_o.accepted),
  .slot_i        (out_o.slot),
  .entry_count_i (out_o.entry_count)
);

[bench/bounded_sorted_measurement_list_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded sorted measurement list testbench
// Drives measurements into the sector list and checks every insertion result
// against its typed row or a list model. A directed table covers the
// tie rules, the extremes and the full-list cases. A long random run follows,
// with time-ordered traffic around a rising clock base, old noise items,
// random idling on both channels, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module bounded_sorted_measurement_list_tb;
  import bsml_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [TimeW-1:0] TIME_MAX = '1;

  // One insertion result as it leaves the block.
  typedef struct packed {
    logic              accepted;
    logic [SlotW-1:0]  slot;
    logic [SlotW-1:0]  entry_count;
    logic [RangeW-1:0] front_range;
  } outcome_t;

  // One row of the directed table. Rows with a typed outcome are checked
  // against that value; the others against the list model below.
  typedef struct {
    entry_t   meas;
    bit       typed;
    outcome_t want;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bsml_meas_if   meas_ch ();
  bsml_result_if res_ch ();

  bounded_sorted_measurement_list #(
    .MAX_ENTRIES (LIST_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (meas_ch),
    .out_o  (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // Model of the sector list: entries newest first, ties nearest first.
  entry_t      sector_list [LIST_DEPTH];
  int unsigned list_fill = 0;

  // Results still owed by the block, oldest first.
  outcome_t    owed_results [$];
  plan_row_t   plan [$];
  int unsigned mismatch_count = 0;

  // Traffic shaping shared by the sender and the receiver.
  bit steady        = 1'b0;  // no idling on either side while set
  bit hold_off_req  = 1'b0;  // sender asks the receiver for one long stall
  bit hold_off_done = 1'b0;

  // Files one measurement into the model list and returns the result the
  // block must report for it.
  function automatic outcome_t file_measurement(entry_t m);
    int unsigned place;
    int unsigned last;
    outcome_t    o;
    place = 0;
    // Skip every entry that is strictly newer than the measurement.
    while (place < list_fill && m.timestamp < sector_list[place].timestamp) place++;
    // Among equal times, skip the strictly nearer entries; an exact tie in
    // time and range lands in front of the existing entry.
    while (place < list_fill && m.timestamp == sector_list[place].timestamp &&
           m.range_mm > sector_list[place].range_mm) place++;
    o.accepted = (place < LIST_DEPTH);
    if (o.accepted) begin
      // A full list loses its last entry; otherwise the list grows by one.
      last = (list_fill < LIST_DEPTH) ? list_fill : LIST_DEPTH - 1;
      if (list_fill < LIST_DEPTH) list_fill++;
      for (int unsigned k = last; k > place; k--) sector_list[k] = sector_list[k-1];
      sector_list[place] = m;
    end
    o.slot        = SlotW'(place);
    o.entry_count = SlotW'(list_fill);
    o.front_range = (list_fill > 0) ? sector_list[0].range_mm : '0;
    return o;
  endfunction

  function automatic void plan_row(logic [TimeW-1:0] ts, logic [RangeW-1:0] rng,
                                   logic [BrgW-1:0] brg, logic signed [PosW-1:0] px,
                                   logic signed [PosW-1:0] py, bit typed, logic acc,
                                   int unsigned slot, int unsigned cnt,
                                   logic [RangeW-1:0] front);
    plan_row_t r;
    r.meas.timestamp     = ts;
    r.meas.range_mm      = rng;
    r.meas.bearing       = brg;
    r.meas.pos_x         = px;
    r.meas.pos_y         = py;
    r.typed              = typed;
    r.want.accepted      = acc;
    r.want.slot          = SlotW'(slot);
    r.want.entry_count   = SlotW'(cnt);
    r.want.front_range   = front;
    plan.push_back(r);
  endfunction

  // Offers one measurement, idling first at random, and records the owed
  // result once the block takes the item. Called at a rising edge.
  task automatic offer_meas(entry_t m, bit typed, outcome_t want);
    outcome_t predicted;
    while (!steady && $urandom_range(0, 99) < 28) begin
      meas_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    meas_ch.valid     <= 1'b1;
    meas_ch.timestamp <= m.timestamp;
    meas_ch.range_mm  <= m.range_mm;
    meas_ch.bearing   <= m.bearing;
    meas_ch.pos_x     <= m.pos_x;
    meas_ch.pos_y     <= m.pos_y;
    @(posedge clk_i);
    while (!meas_ch.ready) @(posedge clk_i);
    // The model always advances so that its state follows the block, even on
    // rows whose outcome is typed into the table.
    predicted = file_measurement(m);
    owed_results.push_back(typed ? want : predicted);
  endtask

  // Sender: reset, directed table, random traffic, drain and verdict.
  initial begin
    entry_t           m;
    outcome_t         none;
    logic [TimeW-1:0] clock_base;
    int unsigned      pick;
    int unsigned      jump;

    none = '0;
    meas_ch.valid     = 1'b0;
    meas_ch.timestamp = '0;
    meas_ch.range_mm  = '0;
    meas_ch.bearing   = '0;
    meas_ch.pos_x     = '0;
    meas_ch.pos_y     = '0;

    // Directed table. Rows start at an empty list: the first entry, an exact
    // tie that goes in front, a nearer entry at equal time, a farther one
    // that goes behind all equal times, then newest and oldest extremes.
    plan_row(48'd100, 16'd500, 16'h1234, 17'sd100, -17'sd100, 1, 1'b1, 0, 1, 16'd500);
    plan_row(48'd100, 16'd500, 16'h4321, -17'sd1, 17'sd1, 1, 1'b1, 0, 2, 16'd500);
    plan_row(48'd100, 16'd300, 16'h00FF, 17'sd0, 17'sd0, 1, 1'b1, 0, 3, 16'd300);
    plan_row(48'd100, 16'hFFFF, 16'hFF00, 17'sd7, 17'sd9, 1, 1'b1, 3, 4, 16'd300);
    plan_row(48'd200, 16'd0, 16'hAAAA, 17'sd5, 17'sd5, 1, 1'b1, 0, 5, 16'd0);
    plan_row(TIME_MAX, 16'hFFFF, 16'hFFFF, 17'sd65535, -17'sd65536,
             1, 1'b1, 0, 6, 16'hFFFF);
    plan_row(48'd0, 16'd0, 16'h0000, -17'sd65536, 17'sd65535, 1, 1'b1, 6, 7, 16'hFFFF);
    // Fill the list with equal times in scrambled range order.
    plan_row(48'd50, 16'd90, 16'h0001, 17'sd1, 17'sd2, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'd10, 16'h0002, 17'sd3, 17'sd4, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'd50, 16'h0003, 17'sd5, 17'sd6, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'd30, 16'h0004, 17'sd7, 17'sd8, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'd70, 16'h0005, 17'sd9, 17'sd10, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'd20, 16'h0006, -17'sd9, 17'sd11, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'd80, 16'h0007, -17'sd7, 17'sd12, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'd40, 16'h0008, -17'sd5, 17'sd13, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'd60, 16'h0009, -17'sd3, 17'sd14, 0, 1'b0, 0, 0, '0);
    // Full list: oldest and farthest is rejected, an exact tie with the last
    // entry overwrites it, then an insertion in the middle.
    plan_row(48'd0, 16'hFFFF, 16'h5555, 17'sd1, 17'sd1, 1, 1'b0, 16, 16, 16'hFFFF);
    plan_row(48'd0, 16'd0, 16'h6666, 17'sd2, 17'sd2, 1, 1'b1, 15, 16, 16'hFFFF);
    plan_row(48'd75, 16'd1, 16'h7777, 17'sd3, 17'sd3, 0, 1'b0, 0, 0, '0);
    // Place at the last slot by range, then one just past the end.
    plan_row(48'd50, 16'd85, 16'h8888, 17'sd4, 17'sd4, 0, 1'b0, 0, 0, '0);
    plan_row(48'd50, 16'hFFFF, 16'h9999, 17'sd5, 17'sd5, 0, 1'b0, 0, 0, '0);
    // Newest time with the nearest range goes to the front, twice.
    plan_row(TIME_MAX, 16'd0, 16'hBBBB, 17'sd6, 17'sd6, 1, 1'b1, 0, 16, 16'd0);
    plan_row(TIME_MAX, 16'd0, 16'hCCCC, 17'sd7, 17'sd7, 1, 1'b1, 0, 16, 16'd0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) offer_meas(plan[i].meas, plan[i].typed, plan[i].want);

    // Random traffic. Most items are a little older than a slowly rising
    // clock base, with narrow ranges so that ties in time and range are
    // common and places fall anywhere in the list, past its end too. The
    // base jumps upward a few times, ending just below the largest time,
    // so that every timestamp bit is exercised. Old noise items are mixed in.
    clock_base = 48'd1000;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 350 && i < 500);
      if (i == 150) hold_off_req = 1'b1;
      if (i == 600) begin
        // Let the block run dry before going on.
        meas_ch.valid <= 1'b0;
        do @(posedge clk_i); while (owed_results.size() != 0);
      end
      if (i % 110 == 109) begin
        jump = (i + 1) / 110;
        if (jump >= 6) clock_base = TIME_MAX - 48'd3000;
        else clock_base = (TIME_MAX / 6) * jump + TimeW'($urandom);
      end else begin
        clock_base = clock_base + TimeW'($urandom_range(0, 4));
      end

      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        m.timestamp = TimeW'({$urandom, $urandom}) % clock_base;
        m.range_mm  = RangeW'($urandom);
      end else begin
        m.timestamp = (pick < 20) ? clock_base : clock_base - TimeW'($urandom_range(0, 12));
        m.range_mm  = ($urandom_range(0, 99) < 20) ? RangeW'($urandom)
                                                  : RangeW'($urandom_range(0, 40));
      end
      m.bearing = BrgW'($urandom);
      m.pos_x   = PosW'($urandom);
      m.pos_y   = PosW'($urandom);
      offer_meas(m, 1'b0, none);
    end
    meas_ch.valid <= 1'b0;
    steady = 1'b0;

    while (owed_results.size() != 0) @(posedge clk_i);
    // Anything arriving now is a spurious result and counts as a failure.
    repeat (80) @(posedge clk_i);

    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("PASS bounded_sorted_measurement_list");
    end else begin
      $display("FAIL bounded_sorted_measurement_list");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off on request, and a
  // stretch without idling while the sender runs steady.
  initial begin
    int unsigned waited;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        // The block takes one more item while its result register is
        // occupied, then has to hold its input off.
        res_ch.ready <= 1'b0;
        for (waited = 0; waited < HOLD_CYCLES; waited++) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      res_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
    end
  end

  // Result checker: each accepted result against the oldest owed one.
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.accepted    = res_ch.accepted;
      got.slot        = res_ch.slot;
      got.entry_count = res_ch.entry_count;
      got.front_range = res_ch.front_range;
      if (owed_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing owed: acc=%0b slot=%0d count=%0d front=%0d",
                   $realtime, got.accepted, got.slot, got.entry_count, got.front_range);
      end else begin
        want = owed_results.pop_front();
        if (got.accepted !== want.accepted || got.slot !== want.slot ||
            got.entry_count !== want.entry_count || got.front_range !== want.front_range) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: expected acc=%0b slot=%0d count=%0d front=%0d, %s",
                     $realtime, want.accepted, want.slot, want.entry_count,
                     want.front_range,
                     $sformatf("got acc=%0b slot=%0d count=%0d front=%0d",
                               got.accepted, got.slot, got.entry_count, got.front_range));
        end
      end
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL bounded_sorted_measurement_list");
    $finish;
  end

endmodule
